FILE: rtl/core/websocket_frame_parser_assert.svh
// Assertion macros shared by the checker of the frame parser.
// Each macro takes a label, an antecedent and a consequent, and uses the
// clk and rst_n names of the module that expands it.
`ifndef WEBSOCKET_FRAME_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define WSFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed one cycle later");

`endif

FILE: rtl/core/wsfp_pkg.sv
package wsfp_pkg;

    // Width of the decoded payload length (top bit of a 64-bit length is dropped).
    localparam int LEN_W = 63;

    // Result queue between parser and output stage; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Output beat layout.
    localparam int TDATA_W = 80;

    // Event kinds carried on tuser.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Byte counts of the extended lengths and the mask key.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // One result as it travels from parser to output.
    typedef struct packed {
        logic [1:0]       kind;
        logic             fin;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
        logic             end_of_frame;
        logic             last;
    } result_t;

    // Up to two results written into the queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Oldest queue entry as seen by the output stage.
    typedef struct packed {
        logic    valid;
        result_t result;
    } qhead_t;

endpackage

FILE: rtl/core/wsfp_front.sv
module wsfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,     // [7:0] stream_byte
    input  logic                room,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    output wsfp_pkg::push_t     push
);

    typedef enum logic [2:0] {
        PH_START,
        PH_HEAD,
        PH_LENGTH,
        PH_MASK,
        PH_BODY
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic                         fin_reg, fin_next;
    logic [3:0]                   opcode_reg, opcode_next;
    logic                         masked_reg, masked_next;
    logic [wsfp_pkg::LEN_W-1:0]   length_reg, length_next;
    logic [3:0]                   bytes_needed_reg, bytes_needed_next;
    logic [wsfp_pkg::LEN_W-1:0]   remaining_reg, remaining_next;
    logic [7:0]                   mask_key_reg [4];
    logic [7:0]                   mask_key_next [4];
    logic [1:0]                   key_pos_reg, key_pos_next;
    logic                         unmask_reg, unmask_next;

    logic                         accept;
    logic                         len_done;
    logic                         hdr_done;
    logic [1:0]                   key_idx;
    logic [7:0]                   body_byte;
    logic                         body_end;

    assign accept        = s_axis_tvalid && room;
    assign s_axis_tready = room;
    assign key_idx       = 2'(wsfp_pkg::KEY_BYTES - bytes_needed_reg);
    assign body_byte     = (masked_reg && unmask_reg) ?
                           (s_axis_tdata ^ mask_key_reg[key_pos_reg]) : s_axis_tdata;
    assign body_end      = (remaining_reg == wsfp_pkg::LEN_W'(1));

    // Parse the accepted byte and form the results it causes.
    always_comb
    begin
        phase_next        = phase_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        masked_next       = masked_reg;
        length_next       = length_reg;
        bytes_needed_next = bytes_needed_reg;
        remaining_next    = remaining_reg;
        mask_key_next     = mask_key_reg;
        key_pos_next      = key_pos_reg;
        unmask_next       = cfg_valid ? cfg_data : unmask_reg;
        len_done          = 1'b0;
        hdr_done          = 1'b0;
        push              = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    masked_next = s_axis_tdata[7];
                    length_next = '0;
                    if (s_axis_tdata[6:0] == wsfp_pkg::LEN7_EXT16)
                    begin
                        bytes_needed_next = wsfp_pkg::EXT16_BYTES;
                        phase_next        = PH_LENGTH;
                    end
                    else if (s_axis_tdata[6:0] == wsfp_pkg::LEN7_EXT64)
                    begin
                        bytes_needed_next = wsfp_pkg::EXT64_BYTES;
                        phase_next        = PH_LENGTH;
                    end
                    else
                    begin
                        length_next = wsfp_pkg::LEN_W'(s_axis_tdata[6:0]);
                        len_done    = 1'b1;
                    end
                end
                PH_LENGTH:
                begin
                    // Big-endian: shift in at the bottom, the top bits fall off.
                    length_next       = {length_reg[wsfp_pkg::LEN_W-9:0], s_axis_tdata};
                    bytes_needed_next = bytes_needed_reg - 4'd1;
                    len_done          = (bytes_needed_reg == 4'd1);
                end
                PH_MASK:
                begin
                    mask_key_next[key_idx] = s_axis_tdata;
                    bytes_needed_next      = bytes_needed_reg - 4'd1;
                    hdr_done               = (bytes_needed_reg == 4'd1);
                end
                PH_BODY:
                begin
                    key_pos_next    = key_pos_reg + 2'd1;
                    remaining_next  = remaining_reg - wsfp_pkg::LEN_W'(1);
                    push.count      = 2'd1;
                    push.first.kind         = wsfp_pkg::KIND_PAYLOAD;
                    push.first.fin          = fin_reg;
                    push.first.opcode       = opcode_reg;
                    push.first.masked       = masked_reg;
                    push.first.length       = length_reg;
                    push.first.data         = body_byte;
                    push.first.end_of_frame = body_end;
                    push.first.last         = 1'b1;
                    if (body_end)
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    // Start of a frame; unknown phase codes land here too.
                    fin_next          = s_axis_tdata[7];
                    opcode_next       = s_axis_tdata[3:0];
                    masked_next       = 1'b0;
                    length_next       = '0;
                    bytes_needed_next = '0;
                    remaining_next    = '0;
                    phase_next        = PH_HEAD;
                end
            endcase

            // Length complete: collect the mask key or close the header.
            if (len_done)
            begin
                if (masked_next)
                begin
                    bytes_needed_next = wsfp_pkg::KEY_BYTES;
                    key_pos_next      = '0;
                    phase_next        = PH_MASK;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: header event, then an end event or the body.
            if (hdr_done)
            begin
                key_pos_next             = '0;
                push.first.kind          = wsfp_pkg::KIND_HEADER;
                push.first.fin           = fin_next;
                push.first.opcode        = opcode_next;
                push.first.masked        = masked_next;
                push.first.length        = length_next;
                push.first.data          = '0;
                push.first.end_of_frame  = 1'b0;
                push.second              = push.first;
                push.second.kind         = wsfp_pkg::KIND_END;
                push.second.end_of_frame = 1'b1;
                push.second.last         = 1'b1;
                if (length_next == '0)
                begin
                    push.count      = 2'd2;
                    push.first.last = 1'b0;
                    phase_next      = PH_START;
                end
                else
                begin
                    push.count      = 2'd1;
                    push.first.last = 1'b1;
                    remaining_next  = length_next;
                    phase_next      = PH_BODY;
                end
            end
        end
    end

    // Parser state and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            fin_reg          <= 1'b0;
            opcode_reg       <= '0;
            masked_reg       <= 1'b0;
            length_reg       <= '0;
            bytes_needed_reg <= '0;
            remaining_reg    <= '0;
            mask_key_reg     <= '{default: '0};
            key_pos_reg      <= '0;
            unmask_reg       <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            masked_reg       <= masked_next;
            length_reg       <= length_next;
            bytes_needed_reg <= bytes_needed_next;
            remaining_reg    <= remaining_next;
            mask_key_reg     <= mask_key_next;
            key_pos_reg      <= key_pos_next;
            unmask_reg       <= unmask_next;
        end
    end

endmodule

FILE: rtl/core/wsfp_queue.sv
module wsfp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  wsfp_pkg::push_t    push,
    input  logic               pop,
    output wsfp_pkg::qhead_t   head,
    output logic               room
);

    wsfp_pkg::result_t              entry_reg [wsfp_pkg::QUEUE_DEPTH];
    logic [wsfp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [wsfp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [wsfp_pkg::QPTR_W:0]      count_reg, count_next;
    logic [wsfp_pkg::QPTR_W-1:0]    wr_ptr_second;
    logic                           pop_ok;

    assign wr_ptr_second = wr_ptr_reg + wsfp_pkg::QPTR_W'(1);
    assign pop_ok        = pop && (count_reg != '0);
    assign wr_ptr_next   = wr_ptr_reg + wsfp_pkg::QPTR_W'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + wsfp_pkg::QPTR_W'(pop_ok);
    assign count_next    = count_reg + (wsfp_pkg::QPTR_W + 1)'(push.count)
                           - (wsfp_pkg::QPTR_W + 1)'(pop_ok);

    // There must be space for the two results a single byte can cause.
    assign room          = (count_reg <= (wsfp_pkg::QPTR_W + 1)'(wsfp_pkg::QUEUE_DEPTH - 2));
    assign head.valid    = (count_reg != '0);
    assign head.result   = entry_reg[rd_ptr_reg];

    // Entry storage: first result at the write pointer, second just after it.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wsfp_pkg::QUEUE_DEPTH; i++)
        begin
            if ((push.count != 2'd0) && (wr_ptr_reg == wsfp_pkg::QPTR_W'(i)))
            begin
                entry_reg[i] <= push.first;
            end
            else if ((push.count == 2'd2) && (wr_ptr_second == wsfp_pkg::QPTR_W'(i)))
            begin
                entry_reg[i] <= push.second;
            end
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/wsfp_back.sv
module wsfp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wsfp_pkg::qhead_t                    head,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] fin_bit, [4:1] opcode, [5] masked_flag, [68:6] payload_length,
    // [76:69] payload_byte, [77] end_of_frame, [79:78] zero
    output logic [wsfp_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,   // [1:0] event_kind
    output logic                                m_axis_tlast    // last_of_run
);

    logic               out_valid_reg, out_valid_next;
    wsfp_pkg::result_t  out_result_reg;

    // Load a new beat when the output register is empty or being taken.
    assign pop            = head.valid && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = pop || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_result_reg <= head.result;
        end
    end

    // Pack the result into the output beat.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_result_reg.end_of_frame,
                            out_result_reg.data,
                            out_result_reg.length,
                            out_result_reg.masked,
                            out_result_reg.opcode,
                            out_result_reg.fin};
    assign m_axis_tuser  = out_result_reg.kind;
    assign m_axis_tlast  = out_result_reg.last;

endmodule

FILE: rtl/core/websocket_frame_parser.sv
// WebSocket frame parser. One stream byte is taken per cycle on s_axis while
// the four-entry result queue has space for two results; that queue and the
// output register drain one beat per cycle on m_axis while m_axis_tready is
// high, so a steady byte stream runs at one byte per cycle and only the
// empty-frame case (header plus end event from one byte) gives two beats for
// one byte. A result enters the queue at the edge that takes its byte, then
// the output register once that is free. Headers give a header beat once the
// length and any mask key are complete; payload bytes follow, unmasked when
// cfg_data last written was 1 (the reset value). Configuration writes are
// always taken and should be made while the block is idle.
module websocket_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] stream_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] fin_bit, [4:1] opcode, [5] masked_flag, [68:6] payload_length,
    // [76:69] payload_byte, [77] end_of_frame, [79:78] zero
    output logic [wsfp_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic [1:0]                      m_axis_tuser,   // [1:0] event_kind
    output logic                            m_axis_tlast,   // last_of_run
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data        // unmask_enable
);

    wsfp_pkg::push_t    push;
    wsfp_pkg::qhead_t   head;
    logic               room;
    logic               pop;

    assign cfg_ready = 1'b1;

    // Byte parser.
    wsfp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .room          (room),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .push          (push)
    );

    // Result queue.
    wsfp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .room  (room)
    );

    // Output stage.
    wsfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/core/wsfp_checker.sv
`include "websocket_frame_parser_assert.svh"

module wsfp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [wsfp_pkg::TDATA_W-1:0]    m_axis_tdata,
    input  logic [1:0]                      m_axis_tuser,
    input  logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_data
);

    logic is_header;
    logic is_end;
    logic out_beat;
    logic in_beat;
    logic cfg_beat;

    assign is_header = m_axis_tvalid && (m_axis_tuser == wsfp_pkg::KIND_HEADER);
    assign is_end    = m_axis_tvalid && (m_axis_tuser == wsfp_pkg::KIND_END);
    assign out_beat  = m_axis_tvalid && m_axis_tready;
    assign in_beat   = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
    assign cfg_beat  = cfg_valid && cfg_ready && (cfg_data == cfg_data);

    // A header ends its run exactly when the frame has a payload.
    `WSFP_ASSERT_NOW(a_header_last, is_header, m_axis_tlast == (m_axis_tdata[68:6] != '0))

    // An end event is an empty frame's closing beat with no data.
    `WSFP_ASSERT_NOW(a_end_shape, is_end, m_axis_tlast && m_axis_tdata[77] && (m_axis_tdata[76:6] == '0))

    // The end event of an empty frame follows its header directly.
    `WSFP_ASSERT_NEXT(a_end_follows, out_beat && is_header && !m_axis_tlast, is_end)

    // A stalled output beat holds.
    `WSFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Reset idles the output.
    `WSFP_ASSERT_NEXT(a_idle_after_reset, !in_beat && !cfg_beat && !m_axis_tvalid && $past(!rst_n), !m_axis_tvalid)

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);
